// File: rtl/drqe_pkg.sv
// Shared types and constants for the dual record queue engine.
package drqe_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // One stored record.
    typedef struct packed {
        logic signed [31:0] code;
        logic [4:0]         day;
        logic [3:0]         month;
    } record_t;

    localparam int REC_W = $bits(record_t);

    // Command codes; the eighth code is unused and behaves as a no-op.
    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_READOUT  = 3'd1,
        CMD_REMOVE   = 3'd2,
        CMD_COUNTS   = 3'd3,
        CMD_COPY     = 3'd4,
        CMD_TRANSFER = 3'd5,
        CMD_DIVIDE   = 3'd6
    } cmd_e;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_e;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // latch a new request and set up the walk
        logic walk_en;  // issue one store read per cycle while entries remain
        logic finish;   // commit counts and emit the closing result
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic walk_done;     // all reads issued and the last one processed
        logic final_needed;  // a closing result still has to be emitted
    } dp_status_t;

endpackage

// File: rtl/drqe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module drqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/drqe_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module drqe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2:0]            command,
    input  drqe_pkg::dp_status_t  sts,
    output drqe_pkg::ctrl_cmd_t   ctl,
    output logic                  busy
);

    drqe_pkg::state_t state_reg;
    drqe_pkg::state_t state_next;
    logic             cmd_walks;

    // Commands that step through stored entries.
    always_comb
    begin
        unique case (command)
            drqe_pkg::CMD_READOUT,
            drqe_pkg::CMD_REMOVE,
            drqe_pkg::CMD_COPY,
            drqe_pkg::CMD_TRANSFER,
            drqe_pkg::CMD_DIVIDE: cmd_walks = 1'b1;
            default:              cmd_walks = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            drqe_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = cmd_walks ? drqe_pkg::S_WALK : drqe_pkg::S_FINISH;
                end
            end
            drqe_pkg::S_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = sts.final_needed ? drqe_pkg::S_FINISH : drqe_pkg::S_IDLE;
                end
            end
            drqe_pkg::S_FINISH:
            begin
                state_next = drqe_pkg::S_IDLE;
            end
            default:
            begin
                state_next = drqe_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drqe_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Outputs decoded from the state.
    always_comb
    begin
        ctl.load    = 1'b0;
        ctl.walk_en = 1'b0;
        ctl.finish  = 1'b0;
        busy        = 1'b1;
        unique case (state_reg)
            drqe_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            drqe_pkg::S_WALK:
            begin
                ctl.walk_en = 1'b1;
            end
            drqe_pkg::S_FINISH:
            begin
                ctl.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/drqe_datapath.sv
// Datapath: both record stores, fill counts, the entry walk and the result registers.
module drqe_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  drqe_pkg::ctrl_cmd_t                  ctl,
    output drqe_pkg::dp_status_t                 sts,
    input  logic [2:0]                           command,
    input  logic                                 queue_select,
    input  logic signed [31:0]                   record_code,
    input  logic [4:0]                           record_day,
    input  logic [3:0]                           record_month,
    output logic                                 result_strobe,
    output logic [1:0]                           status,
    output logic signed [31:0]                   out_code,
    output logic [4:0]                           out_day,
    output logic [3:0]                           out_month,
    output logic [drqe_pkg::CNT_W-1:0]           main_count,
    output logic [drqe_pkg::CNT_W-1:0]           aux_count,
    output logic                                 last
);

    localparam logic [drqe_pkg::CNT_W-1:0] FULL_CNT = drqe_pkg::CNT_W'(drqe_pkg::QUEUE_DEPTH);

    // Request registers.
    logic [2:0]                  cmd_reg;
    logic                        sel_reg;
    drqe_pkg::record_t           rec_reg;

    // Fill counts.
    logic [drqe_pkg::CNT_W-1:0]  main_fill_reg;
    logic [drqe_pkg::CNT_W-1:0]  main_fill_next;
    logic [drqe_pkg::CNT_W-1:0]  aux_fill_reg;
    logic [drqe_pkg::CNT_W-1:0]  aux_fill_next;

    // Walk counters and flags.
    logic [drqe_pkg::CNT_W-1:0]  src_reg;
    logic [drqe_pkg::CNT_W-1:0]  end_reg;
    logic [drqe_pkg::CNT_W-1:0]  dst_reg;
    logic [drqe_pkg::ADDR_W-1:0] didx_reg;
    logic                        rv_reg;
    logic                        found_reg;
    logic                        full_reg;

    // Result registers.
    logic                        strobe_reg;
    drqe_pkg::status_e           status_reg;
    drqe_pkg::record_t           orec_reg;
    logic [drqe_pkg::CNT_W-1:0]  omain_reg;
    logic [drqe_pkg::CNT_W-1:0]  oaux_reg;
    logic                        last_reg;

    // Store ports.
    logic                        main_we;
    logic [drqe_pkg::ADDR_W-1:0] main_waddr;
    drqe_pkg::record_t           main_wdata;
    logic [drqe_pkg::REC_W-1:0]  main_rdata;
    logic                        aux_we;
    logic [drqe_pkg::REC_W-1:0]  aux_rdata;
    drqe_pkg::record_t           main_rec;
    drqe_pkg::record_t           rd_rec;

    // Walk decode.
    logic                        issue;
    logic                        key_match;
    logic                        is_move;
    logic                        is_readout;
    logic                        readout_last;
    drqe_pkg::status_e           fin_status;
    logic [drqe_pkg::CNT_W-1:0]  src_start;
    logic [drqe_pkg::CNT_W-1:0]  end_start;
    logic [drqe_pkg::CNT_W-1:0]  dst_start;

    drqe_ram #(
        .WIDTH (drqe_pkg::REC_W),
        .DEPTH (drqe_pkg::QUEUE_DEPTH)
    ) u_main_ram (
        .clk   (clk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .raddr (src_reg[drqe_pkg::ADDR_W-1:0]),
        .rdata (main_rdata)
    );

    drqe_ram #(
        .WIDTH (drqe_pkg::REC_W),
        .DEPTH (drqe_pkg::QUEUE_DEPTH)
    ) u_aux_ram (
        .clk   (clk),
        .we    (aux_we),
        .waddr (dst_reg[drqe_pkg::ADDR_W-1:0]),
        .wdata (main_rdata),
        .raddr (src_reg[drqe_pkg::ADDR_W-1:0]),
        .rdata (aux_rdata)
    );

    assign main_rec   = drqe_pkg::record_t'(main_rdata);
    assign is_readout = (cmd_reg == drqe_pkg::CMD_READOUT);
    assign rd_rec     = (is_readout && sel_reg) ? drqe_pkg::record_t'(aux_rdata) : main_rec;
    assign key_match  = (main_rec.code == rec_reg.code);
    assign is_move    = (cmd_reg == drqe_pkg::CMD_COPY) || (cmd_reg == drqe_pkg::CMD_TRANSFER)
                        || (cmd_reg == drqe_pkg::CMD_DIVIDE);
    assign issue      = ctl.walk_en && (src_reg != end_reg);
    assign readout_last = ((drqe_pkg::CNT_W'(didx_reg) + drqe_pkg::CNT_W'(1)) == end_reg);

    // Status toward the controller.
    assign sts.walk_done    = (src_reg == end_reg) && !rv_reg;
    assign sts.final_needed = !(is_readout && (end_reg != '0));

    // Walk range chosen when a request is taken.
    always_comb
    begin
        src_start = '0;
        dst_start = '0;
        end_start = main_fill_reg;
        if (command == drqe_pkg::CMD_DIVIDE)
        begin
            src_start = main_fill_reg >> 1;
        end
        if (command == drqe_pkg::CMD_COPY)
        begin
            dst_start = aux_fill_reg;
        end
        if ((command == drqe_pkg::CMD_READOUT) && queue_select)
        begin
            end_start = aux_fill_reg;
        end
    end

    // Main store write: insert at the tail, or shift an entry down behind a removed one.
    always_comb
    begin
        main_we    = 1'b0;
        main_waddr = main_fill_reg[drqe_pkg::ADDR_W-1:0];
        main_wdata = rec_reg;
        priority if (ctl.finish && (cmd_reg == drqe_pkg::CMD_INSERT)
                     && (main_fill_reg != FULL_CNT))
        begin
            main_we = 1'b1;
        end
        else if (rv_reg && (cmd_reg == drqe_pkg::CMD_REMOVE) && found_reg)
        begin
            main_we    = 1'b1;
            main_waddr = didx_reg - drqe_pkg::ADDR_W'(1);
            main_wdata = main_rec;
        end
        else
        begin
            main_we = 1'b0;
        end
    end

    // Auxiliary store write while moving entries over, dropped once it is full.
    assign aux_we = rv_reg && is_move && (dst_reg != FULL_CNT);

    // Closing status and committed counts.
    always_comb
    begin
        fin_status     = drqe_pkg::ST_OK;
        main_fill_next = main_fill_reg;
        aux_fill_next  = aux_fill_reg;
        unique case (cmd_reg)
            drqe_pkg::CMD_INSERT:
            begin
                if (main_fill_reg == FULL_CNT)
                begin
                    fin_status = drqe_pkg::ST_FULL;
                end
                else
                begin
                    main_fill_next = main_fill_reg + drqe_pkg::CNT_W'(1);
                end
            end
            drqe_pkg::CMD_READOUT:
            begin
                fin_status = drqe_pkg::ST_EMPTY;
            end
            drqe_pkg::CMD_REMOVE:
            begin
                if (main_fill_reg == '0)
                begin
                    fin_status = drqe_pkg::ST_EMPTY;
                end
                else if (found_reg)
                begin
                    main_fill_next = main_fill_reg - drqe_pkg::CNT_W'(1);
                end
                else
                begin
                    fin_status = drqe_pkg::ST_NOT_FOUND;
                end
            end
            drqe_pkg::CMD_COPY:
            begin
                aux_fill_next = dst_reg;
                fin_status    = full_reg ? drqe_pkg::ST_FULL : drqe_pkg::ST_OK;
            end
            drqe_pkg::CMD_TRANSFER:
            begin
                aux_fill_next  = dst_reg;
                main_fill_next = '0;
            end
            drqe_pkg::CMD_DIVIDE:
            begin
                aux_fill_next  = dst_reg;
                main_fill_next = main_fill_reg >> 1;
                if (main_fill_reg == '0)
                begin
                    fin_status = drqe_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                fin_status = drqe_pkg::ST_OK;
            end
        endcase
    end

    // Control state: counts, walk counters and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_fill_reg <= '0;
            aux_fill_reg  <= '0;
            src_reg       <= '0;
            end_reg       <= '0;
            dst_reg       <= '0;
            rv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            cmd_reg       <= drqe_pkg::CMD_COUNTS;
            sel_reg       <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                cmd_reg   <= command;
                sel_reg   <= queue_select;
                src_reg   <= src_start;
                end_reg   <= end_start;
                dst_reg   <= dst_start;
                found_reg <= 1'b0;
                full_reg  <= 1'b0;
            end
            if (ctl.finish)
            begin
                main_fill_reg <= main_fill_next;
                aux_fill_reg  <= aux_fill_next;
            end
            // One read issued per cycle; its data is handled in the next cycle.
            rv_reg <= issue;
            if (issue)
            begin
                src_reg <= src_reg + drqe_pkg::CNT_W'(1);
            end
            if (rv_reg && (cmd_reg == drqe_pkg::CMD_REMOVE) && !found_reg && key_match)
            begin
                found_reg <= 1'b1;
            end
            if (rv_reg && is_move)
            begin
                if (dst_reg == FULL_CNT)
                begin
                    full_reg <= 1'b1;
                end
                else
                begin
                    dst_reg <= dst_reg + drqe_pkg::CNT_W'(1);
                end
            end
            strobe_reg <= ctl.finish || (rv_reg && is_readout);
        end
    end

    // Payload: request record, read index and result fields.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rec_reg.code  <= record_code;
            rec_reg.day   <= record_day;
            rec_reg.month <= record_month;
        end
        if (issue)
        begin
            didx_reg <= src_reg[drqe_pkg::ADDR_W-1:0];
        end
        if (ctl.finish)
        begin
            status_reg <= fin_status;
            orec_reg   <= '0;
            omain_reg  <= main_fill_next;
            oaux_reg   <= aux_fill_next;
            last_reg   <= 1'b1;
        end
        else if (rv_reg && is_readout)
        begin
            status_reg <= drqe_pkg::ST_OK;
            orec_reg   <= rd_rec;
            omain_reg  <= main_fill_reg;
            oaux_reg   <= aux_fill_reg;
            last_reg   <= readout_last;
        end
    end

    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign out_code      = orec_reg.code;
    assign out_day       = orec_reg.day;
    assign out_month     = orec_reg.month;
    assign main_count    = omain_reg;
    assign aux_count     = oaux_reg;
    assign last          = last_reg;

endmodule

// File: rtl/dual_record_queue_engine_core.sv
// Top level of the dual record queue engine: controller, datapath and checks.
//
// Channel   Signals                                          Handshake
// request   command queue_select record_code record_day      start high while busy low
//           record_month
// result    status out_code out_day out_month main_count     result_strobe, one cycle
//           aux_count last
//
// Insert, counts and the unused code go straight from idle to the closing step and back.
// Read out walks the n entries of the selected queue; remove, copy and transfer walk the
// n entries of main, and divide walks main from entry floor(n/2) up; all of these then
// close with a final result, except a read out of a queue that is not empty.
// The walk reads one store entry per cycle through the registered RAM read port.
// Reset clears both counts; store contents stay undefined and are never read unwritten.
// Results come out one per cycle with no back-pressure; busy holds requests off.
module dual_record_queue_engine_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 command,
    input  logic                       queue_select,
    input  logic signed [31:0]         record_code,
    input  logic [4:0]                 record_day,
    input  logic [3:0]                 record_month,
    output logic                       result_strobe,
    output logic [1:0]                 status,
    output logic signed [31:0]         out_code,
    output logic [4:0]                 out_day,
    output logic [3:0]                 out_month,
    output logic [drqe_pkg::CNT_W-1:0] main_count,
    output logic [drqe_pkg::CNT_W-1:0] aux_count,
    output logic                       last
);

    drqe_pkg::ctrl_cmd_t  ctl;
    drqe_pkg::dp_status_t sts;

    drqe_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .sts     (sts),
        .ctl     (ctl),
        .busy    (busy)
    );

    drqe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .command       (command),
        .queue_select  (queue_select),
        .record_code   (record_code),
        .record_day    (record_day),
        .record_month  (record_month),
        .result_strobe (result_strobe),
        .status        (status),
        .out_code      (out_code),
        .out_day       (out_day),
        .out_month     (out_month),
        .main_count    (main_count),
        .aux_count     (aux_count),
        .last          (last)
    );

    // A taken request keeps the engine busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after a request was taken");

    // Read-out results come back to back until the one marked last.
    a_readout_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |=> result_strobe)
        else $error("gap inside a read-out burst");

    // The closing step always produces a final result in the next cycle.
    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> (result_strobe && last))
        else $error("closing step produced no final result");

    // Reported counts never exceed the queue depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> ((main_count <= drqe_pkg::CNT_W'(drqe_pkg::QUEUE_DEPTH))
                           && (aux_count <= drqe_pkg::CNT_W'(drqe_pkg::QUEUE_DEPTH))))
        else $error("reported count beyond queue depth");

endmodule
